FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: src/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned CNT_W = 3;

	// Code point that replaces every rejected byte.
	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

	// Lead byte ranges.
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [7:0] ASCII_LIM = 8'h80;

	// Leads that restrict the range of their second byte.
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] E0_MIN  = 8'hA0;
	localparam logic [7:0] ED_MAX  = 8'h9F;
	localparam logic [7:0] F0_MIN  = 8'h90;
	localparam logic [7:0] F4_MAX  = 8'h8F;

	// Sequence lengths.
	localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
	localparam logic [CNT_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [CNT_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
	localparam logic [CNT_W-1:0] LEN_FOUR = 3'd4;

	// Everything one input byte produces: a run of replacement results
	// followed by at most one well-formed result.
	typedef struct packed {
		logic [CNT_W-1:0] inv_cnt;
		logic             has_valid;
		logic [CP_W-1:0]  cp;
		logic [CNT_W-1:0] cnt;
		logic             text_end;
		logic             text_valid;
	} rec_t;

endpackage

`default_nettype wire

FILE: src/u8d_decode.sv
// ---------------------------------------------------------------------------
// u8d_decode
// Input register, sequence state and the per-byte decode into a result record.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8d_decode import u8d_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_final,
	input  wire logic       rec_free,
	output logic            rec_push,
	output rec_t            rec
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            final_s1;

	logic [1:0]      pend_q;
	logic [CNT_W-1:0] exp_len_q;
	logic [7:0]      lead_q;
	logic [CP_W-1:0] part_q;
	logic            err_q;

	logic            seq_open;
	logic            is_cont;
	logic            sec_ok;
	logic            take;
	logic            complete;
	logic [1:0]      pend_inc;
	logic [CP_W-1:0] part_shift;
	logic            is_ascii;
	logic            is_bad;
	logic [CNT_W-1:0] open_len;
	logic [CP_W-1:0] open_part;
	logic            open_after;
	logic [1:0]      pend_after;
	logic [CNT_W-1:0] flush_cnt;
	logic [CNT_W-1:0] bad_cnt;
	logic [CNT_W-1:0] trunc_cnt;
	logic [CNT_W-1:0] inv_total;
	logic            has_valid;
	logic            any_result;
	logic            advance;

	// Second-byte range check for the leads with narrowed ranges.
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		ok = 1'b1;
		if (lead == LEAD_E0 && b < E0_MIN) ok = 1'b0;
		if (lead == LEAD_ED && b > ED_MAX) ok = 1'b0;
		if (lead == LEAD_F0 && b < F0_MIN) ok = 1'b0;
		if (lead == LEAD_F4 && b > F4_MAX) ok = 1'b0;
		return ok;
	endfunction

	// Continuation handling for an open sequence.
	always_comb begin
		seq_open   = (exp_len_q != LEN_NONE);
		is_cont    = (byte_s1[7:6] == 2'b10);
		sec_ok     = (pend_q != 2'd0) || second_ok(lead_q, byte_s1);
		take       = seq_open && is_cont && sec_ok;
		pend_inc   = pend_q + 2'd1;
		part_shift = {part_q[CP_W-7:0], byte_s1[5:0]};
		complete   = take && (({1'b0, pend_q} + 3'd2) >= exp_len_q);
	end

	// Classification of the byte taken as a new lead.
	always_comb begin
		is_ascii  = 1'b0;
		is_bad    = 1'b0;
		open_len  = LEN_NONE;
		open_part = '0;
		if (byte_s1 < ASCII_LIM) begin
			is_ascii = 1'b1;
		end else if (byte_s1 inside {[LEAD2_LO:LEAD2_HI]}) begin
			open_len  = LEN_TWO;
			open_part = {16'd0, byte_s1[4:0]};
		end else if (byte_s1 inside {[LEAD3_LO:LEAD3_HI]}) begin
			open_len  = LEN_THREE;
			open_part = {17'd0, byte_s1[3:0]};
		end else if (byte_s1 inside {[LEAD4_LO:LEAD4_HI]}) begin
			open_len  = LEN_FOUR;
			open_part = {18'd0, byte_s1[2:0]};
		end else begin
			is_bad = 1'b1;
		end
	end

	// Result counts: flush of a broken sequence, a rejected lead, and the
	// flush of a sequence still open at the end of the text.
	always_comb begin
		open_after = take ? !complete : (open_len != LEN_NONE);
		pend_after = take ? pend_inc : 2'd0;
		flush_cnt  = (seq_open && !take) ? ({1'b0, pend_q} + 3'd1) : LEN_NONE;
		bad_cnt    = (!take && is_bad) ? LEN_ONE : LEN_NONE;
		trunc_cnt  = (final_s1 && open_after) ? ({1'b0, pend_after} + 3'd1) : LEN_NONE;
		inv_total  = flush_cnt + bad_cnt + trunc_cnt;
		has_valid  = complete || (!take && is_ascii);
		any_result = (inv_total != LEN_NONE) || has_valid;
	end

	// Record handed to the output stage.
	always_comb begin
		rec.inv_cnt    = inv_total;
		rec.has_valid  = has_valid;
		rec.cp         = complete ? part_shift : {13'd0, byte_s1};
		rec.cnt        = complete ? exp_len_q : LEN_ONE;
		rec.text_end   = final_s1;
		rec.text_valid = final_s1 && !err_q && (inv_total == LEN_NONE);
	end

	assign advance  = valid_s1 && (!any_result || rec_free);
	assign rec_push = advance && any_result;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			final_s1 <= in_final;
		end
	end

	// Sequence state update when the byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 2'd0;
			exp_len_q <= LEN_NONE;
			lead_q    <= 8'd0;
			part_q    <= '0;
			err_q     <= 1'b0;
		end else if (advance) begin
			if (final_s1 || complete || (!take && open_len == LEN_NONE)) begin
				pend_q    <= 2'd0;
				exp_len_q <= LEN_NONE;
				lead_q    <= 8'd0;
				part_q    <= '0;
			end else if (take) begin
				pend_q <= pend_inc;
				part_q <= part_shift;
			end else begin
				pend_q    <= 2'd0;
				exp_len_q <= open_len;
				lead_q    <= byte_s1;
				part_q    <= open_part;
			end
			err_q <= !final_s1 && (err_q || (inv_total != LEN_NONE));
		end
	end

	// An idle state has no continuation bytes counted.
	`ASSERT_CLK(a_idle_no_pend, clk, arst_n, (exp_len_q != LEN_NONE) || (pend_q == 2'd0), "pending bytes without open sequence")
	// An open sequence always still waits for at least one byte.
	`ASSERT_CLK(a_pend_below_len, clk, arst_n, (exp_len_q == LEN_NONE) || (({1'b0, pend_q} + 3'd1) < exp_len_q), "open sequence already complete")

endmodule

`default_nettype wire

FILE: src/u8d_emit.sv
// ---------------------------------------------------------------------------
// u8d_emit
// Result register that plays out one record as one or more result transactions.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8d_emit import u8d_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rec_push,
	input  wire rec_t             rec,
	output logic                  rec_free,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [CP_W-1:0]       out_cp,
	output logic [CNT_W-1:0]      out_cnt,
	output logic                  out_ok,
	output logic                  out_run_end,
	output logic                  out_text_end,
	output logic                  out_text_valid
);

	logic rec_valid_q;
	rec_t rec_q;
	logic is_last;
	logic out_fire;

	// Replacement results go out first, the well-formed one last.
	always_comb begin
		is_last = (rec_q.inv_cnt == LEN_NONE) ||
			((rec_q.inv_cnt == LEN_ONE) && !rec_q.has_valid);
		out_fire       = rec_valid_q && out_ready;
		out_valid      = rec_valid_q;
		out_ok         = (rec_q.inv_cnt == LEN_NONE);
		out_cp         = out_ok ? rec_q.cp : REPLACEMENT;
		out_cnt        = out_ok ? rec_q.cnt : LEN_ONE;
		out_run_end    = is_last;
		out_text_end   = is_last && rec_q.text_end;
		out_text_valid = is_last && rec_q.text_end && rec_q.text_valid;
		rec_free       = !rec_valid_q || (out_ready && is_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (rec_push) begin
			rec_valid_q <= 1'b1;
		end else if (out_fire && is_last) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_push) begin
			rec_q <= rec;
		end else if (out_fire && !is_last) begin
			rec_q.inv_cnt <= rec_q.inv_cnt - 3'd1;
		end
	end

	// A record is only loaded when the register is free.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, rec_push && !rec_free, "record overwritten")
	// A held record always has at least one result left and no more than four replacement results.
	`ASSERT_CLK(a_rec_nonempty, clk, arst_n, !rec_valid_q || ((rec_q.inv_cnt != LEN_NONE) || rec_q.has_valid), "empty record held")
	`ASSERT_CLK(a_rec_bound, clk, arst_n, !rec_valid_q || (rec_q.inv_cnt <= LEN_FOUR), "too many replacement results")

endmodule

`default_nettype wire

FILE: src/utf8_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming UTF-8 decoder that replaces rejected bytes with U+FFFD.
// ---------------------------------------------------------------------------
//
// Channel  Dir  tdata (low bit up)                  tuser (low bit up)                 tlast
// s_*      in   text_byte[7:0]                      -                                  final_byte
// m_*      out  code_point[20:0], byte_count[23:21] well_formed, run_end, text_valid   text_end
//
// A byte is decoded combinationally from the input register into the result register,
// so well-formed text streams at one byte per cycle while m_tready is high.
// A byte that produces N results holds the result register until all N are taken
// (N is at most four); bytes that produce no result pass without a slot.
// Reset clears the input register, sequence state and result register at once.
// Back-pressure on m_tready stalls the decode stage and the input register together.
//
`default_nettype none

module utf8_stream_decoder_core import u8d_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // text_byte
	input  wire logic        s_tlast,   // final_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // code_point, byte_count
	output logic [2:0]       m_tuser,   // well_formed, run_end, text_valid
	output logic             m_tlast    // text_end
);

	rec_t             rec;
	logic             rec_push;
	logic             rec_free;
	logic [CP_W-1:0]  out_cp;
	logic [CNT_W-1:0] out_cnt;
	logic             out_ok;
	logic             out_run_end;
	logic             out_text_end;
	logic             out_text_valid;

	// Input register, sequence state and decode.
	u8d_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_final (s_tlast),
		.rec_free (rec_free),
		.rec_push (rec_push),
		.rec      (rec)
	);

	// Result register and result sequencing.
	u8d_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_push       (rec_push),
		.rec            (rec),
		.rec_free       (rec_free),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_cp         (out_cp),
		.out_cnt        (out_cnt),
		.out_ok         (out_ok),
		.out_run_end    (out_run_end),
		.out_text_end   (out_text_end),
		.out_text_valid (out_text_valid)
	);

	// Pack the result fields onto the stream.
	assign m_tdata = {out_cnt, out_cp};
	assign m_tuser = {out_text_valid, out_run_end, out_ok};
	assign m_tlast = out_text_end;

endmodule

`default_nettype wire

FILE: bench/utf8_stream_decoder_core_tb.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Self-checking bench for the streaming UTF-8 decoder with U+FFFD replacement.
// ---------------------------------------------------------------------------
//
// Text bytes go in on the s_* stream and decoded results come out on m_*.
// A scoreboard object keeps its own decoder state and works out the results
// of every accepted byte. It then checks each result transaction, field by
// field, against the oldest result still owed. The stimulus starts with
// hand-picked bytes for the edge cases. It goes on with random texts, which
// are mostly well-formed code points mixed with stray bytes, cut-off
// sequences and bad second bytes. Both sides idle at random, and the
// receiver makes one long stall.
//

module utf8_stream_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8d_pkg::*;

	localparam int unsigned CLK_PERIOD     = 20;
	localparam int unsigned RESET_CYCLES   = 8;
	localparam int unsigned LONG_HOLD      = 200;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned WATCHDOG_LIMIT = 5000;

	// Keeps its own copy of the decoder state and the queue of owed results.
	class decode_scoreboard;
		typedef struct {
			logic [CP_W-1:0]  code_point;
			bit               well_formed;
			logic [CNT_W-1:0] byte_count;
			bit               run_end;
			bit               text_end;
			bit               text_valid;
		} point_t;

		point_t           owed_points[$];
		logic [CNT_W-1:0] open_len;
		logic [1:0]       cont_taken;
		logic [7:0]       lead;
		logic [CP_W-1:0]  scalar;
		bit               err_seen;
		int unsigned      failures;

		function new();
			close_seq();
			err_seen = 1'b0;
			failures = 0;
		endfunction

		function void close_seq();
			open_len   = LEN_NONE;
			cont_taken = 2'd0;
			lead       = 8'h00;
			scalar     = '0;
		endfunction

		function void add_point(logic [CP_W-1:0] cp, bit ok, logic [CNT_W-1:0] cnt);
			point_t p;
			p.code_point  = cp;
			p.well_formed = ok;
			p.byte_count  = cnt;
			p.run_end     = 1'b0;
			p.text_end    = 1'b0;
			p.text_valid  = 1'b0;
			if (!ok) begin
				err_seen = 1'b1;
			end
			owed_points = {owed_points, p};
		endfunction

		// The lead byte and every continuation byte taken so far each become one
		// replacement.
		function void flush_open();
			add_point(REPLACEMENT, 1'b0, LEN_ONE);
			for (int i = 0; i < int'(cont_taken); i++) begin
				add_point(REPLACEMENT, 1'b0, LEN_ONE);
			end
			close_seq();
		endfunction

		// Works out the results of one accepted input transaction.
		function void note_byte(logic [7:0] b, bit last);
			int unsigned first;
			bit taken;
			bit range_ok;
			first = owed_points.size();
			taken = 1'b0;

			// Continue or break the open sequence.
			if (open_len != LEN_NONE) begin
				range_ok = !((lead == LEAD_E0 && b < E0_MIN) || (lead == LEAD_ED && b > ED_MAX) ||
					(lead == LEAD_F0 && b < F0_MIN) || (lead == LEAD_F4 && b > F4_MAX));
				if (b[7:6] == 2'b10 && (cont_taken != 2'd0 || range_ok)) begin
					scalar = {scalar[CP_W-7:0], b[5:0]};
					cont_taken++;
					taken = 1'b1;
					if (int'(cont_taken) + 1 >= int'(open_len)) begin
						add_point(scalar, 1'b1, open_len);
						close_seq();
					end
				end else begin
					flush_open();
				end
			end

			// A byte not taken as a continuation is decoded as a lead.
			if (!taken) begin
				if (b < ASCII_LIM) begin
					add_point(CP_W'(b), 1'b1, LEN_ONE);
				end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					open_len = LEN_TWO;
					lead     = b;
					scalar   = CP_W'(b[4:0]);
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					open_len = LEN_THREE;
					lead     = b;
					scalar   = CP_W'(b[3:0]);
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					open_len = LEN_FOUR;
					lead     = b;
					scalar   = CP_W'(b[2:0]);
				end else begin
					add_point(REPLACEMENT, 1'b0, LEN_ONE);
				end
				cont_taken = 2'd0;
			end

			// A sequence still open at the end of the text is truncated.
			if (last && open_len != LEN_NONE) begin
				flush_open();
			end

			if (owed_points.size() > first) begin
				owed_points[owed_points.size()-1].run_end = 1'b1;
				if (last) begin
					owed_points[owed_points.size()-1].text_end   = 1'b1;
					owed_points[owed_points.size()-1].text_valid = !err_seen;
				end
			end
			if (last) begin
				close_seq();
				err_seen = 1'b0;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				failures++;
			end
		endfunction

		// Checks one result transaction against the oldest owed result.
		function void check_point(logic [23:0] data, logic [2:0] user, logic last);
			point_t want;
			if (owed_points.size() == 0) begin
				$error("result with nothing owed: code_point %0h", data[CP_W-1:0]);
				failures++;
				return;
			end
			want = owed_points.pop_front();
			compare_field("code_point", want.code_point, data[CP_W-1:0]);
			compare_field("byte_count", want.byte_count, data[CP_W+CNT_W-1:CP_W]);
			compare_field("well_formed", want.well_formed, user[0]);
			compare_field("run_end", want.run_end, user[1]);
			compare_field("text_valid", want.text_valid, user[2]);
			compare_field("text_end", want.text_end, last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // code_point, byte_count
	logic [2:0]  m_tuser;   // well_formed, run_end, text_valid
	logic        m_tlast;   // text_end

	decode_scoreboard sb;
	bit          idle_on;
	bit          long_hold_req;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	// Bit 8 is the final flag. The first text walks through the extremes,
	// every rejection kind and a truncation. The second text is one valid byte.
	logic [8:0] directed_bytes [25] = '{
		9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
		9'h0E0, 9'h09F, 9'h0ED, 9'h0A0, 9'h0F0, 9'h08F, 9'h0F4, 9'h090,
		9'h0C0, 9'h0FF, 9'h080, 9'h0E1, 9'h041, 9'h0F1, 9'h080, 9'h180,
		9'h141
	};

	utf8_stream_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// Offers one byte, with an optional idle burst first, and waits for the
	// transaction.
	task automatic send_byte(logic [7:0] b, bit last);
		int unsigned gap;
		if (idle_on && $urandom_range(5, 0) == 0) begin
			gap = $urandom_range(10, 1);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sb.note_byte(b, last);
		items_sent++;
	endtask

	// Drops valid and waits until every owed result has arrived.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.owed_points.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Builds one random text of n_seq pieces and sends it. Most pieces are
	// well-formed code points; the rest are stray bytes, cut-off sequences
	// and leads followed by an out-of-range second byte.
	task automatic send_text(int unsigned n_seq, bit with_final);
		logic [7:0]      text[$];
		logic [7:0]      piece[$];
		logic [CP_W-1:0] cp;
		int unsigned     kind;
		int unsigned     len;
		int unsigned     lo;
		int unsigned     hi;
		for (int unsigned k = 0; k < n_seq; k++) begin
			kind = $urandom_range(99, 0);
			piece.delete();
			if (kind >= 80 && kind < 88) begin
				piece = '{8'($urandom_range(255, 0))};
			end else if (kind >= 94) begin
				case ($urandom_range(3, 0))
					0: piece = '{LEAD_E0, 8'($urandom_range('h9F, 'h80))};
					1: piece = '{LEAD_ED, 8'($urandom_range('hBF, 'hA0))};
					2: piece = '{LEAD_F0, 8'($urandom_range('h8F, 'h80))};
					default: piece = '{LEAD_F4, 8'($urandom_range('hBF, 'h90))};
				endcase
			end else begin
				len = $urandom_range(4, 1);
				case (len)
					1: begin lo = 'h0; hi = 'h7F; end
					2: begin lo = 'h80; hi = 'h7FF; end
					3: begin lo = 'h800; hi = 'hFFFF; end
					default: begin lo = 'h10000; hi = 'h10FFFF; end
				endcase
				// Now and then take an end of the range.
				case ($urandom_range(7, 0))
					0: cp = CP_W'(lo);
					1: cp = CP_W'(hi);
					default: cp = CP_W'($urandom_range(hi, lo));
				endcase
				// Surrogates move up into the valid range above them.
				if (cp >= 'hD800 && cp <= 'hDFFF) begin
					cp ^= 'h2000;
				end
				case (len)
					1: piece = '{cp[7:0]};
					2: piece = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
					3: piece = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
					default: piece = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
						{2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
				endcase
				// Cut off the tail of a multi-byte sequence.
				if (kind >= 88 && len > 1) begin
					repeat ($urandom_range(len - 1, 1)) begin
						void'(piece.pop_back());
					end
				end
			end
			text = {text, piece};
		end
		foreach (text[i]) begin
			send_byte(text[i], with_final && i == text.size() - 1);
		end
	endtask

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		int unsigned hold_left;
		m_tready  = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(9, 0) == 0) begin
				hold_left = $urandom_range(9, 0);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checking and the watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_point(m_tdata, m_tuser, m_tlast);
		end
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tlast       = 1'b0;
		arst_n        = 1'b0;
		idle_on       = 1'b1;
		long_hold_req = 1'b0;
		items_sent    = 0;
		quiet_cycles  = 0;
		sb            = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_bytes[i]) begin
			send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
		end

		// The sender pauses until every owed result is out. Then the receiver
		// holds off while a long text keeps coming, so the decoder backs up.
		wait_drained();
		long_hold_req = 1'b1;
		send_text(30, 1'b1);

		// Random texts; some end without the final flag and run on.
		while (items_sent < 300) begin
			send_text($urandom_range(10, 1), $urandom_range(9, 0) != 0);
		end

		// The last part streams with no idling on either side.
		idle_on = 1'b0;
		while (items_sent < 360) begin
			send_text($urandom_range(10, 1), 1'b1);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: utf8_stream_decoder_core.f
+incdir+src
src/u8d_pkg.sv
src/u8d_decode.sv
src/u8d_emit.sv
src/utf8_stream_decoder_core.sv
bench/utf8_stream_decoder_core_tb.sv
